// ----- hw/rtl/interrupt_priority_controller_top_defines.svh -----
// Assertion macros used by the interrupt priority controller top level.
// No dependencies; included by files that carry concurrent assertions.
`ifndef INTERRUPT_PRIORITY_CONTROLLER_TOP_DEFINES_SVH
`define INTERRUPT_PRIORITY_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ipc_pkg.sv -----
// Shared types and constants of the interrupt priority controller.
// No dependencies; imported by ipc_cell, interrupt_priority_controller_top and tb_top.
package ipc_pkg;

    localparam int LINE_COUNT_DEF = 64;
    localparam int LANES          = 8;   // lines held by one cell
    localparam int IRQ_W          = 8;
    localparam int PRIO_W         = 8;

    localparam logic [PRIO_W-1:0] THREAD_PRIO   = 8'hFF;
    localparam logic [7:0]        DEPTH_MAX     = 8'hFF;
    localparam logic [7:0]        EXC_LINE_BASE = 8'd16;

    localparam logic [31:0] EXC_RET_HANDLER    = 32'hFFFF_FFF1;
    localparam logic [31:0] EXC_RET_THREAD_MSP = 32'hFFFF_FFF9;
    localparam logic [31:0] EXC_RET_THREAD_PSP = 32'hFFFF_FFFD;

    typedef enum logic [2:0] {
        CMD_SET_PEND = 3'd0,
        CMD_CLR_PEND = 3'd1,
        CMD_LVL_HIGH = 3'd2,
        CMD_LVL_LOW  = 3'd3,
        CMD_TAKE     = 3'd4,
        CMD_RETURN   = 3'd5,
        CMD_WR_EN    = 3'd6,
        CMD_WR_PRIO  = 3'd7
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [IRQ_W-1:0]  irq;
        logic [7:0]        value;
        logic              primask;
        logic              faultmask;
        logic [PRIO_W-1:0] basepri;
        logic [7:0]        run_exc;
        logic [31:0]       return_code;
    } req_t;

    typedef struct packed {
        logic [7:0] sel_exc;
        logic       taken;
        logic       return_ok;
        logic       wake;
        logic       pending_bit;
        logic       active_bit;
        logic [7:0] nest_depth;
    } rsp_t;

    // Token that walks the cell chain during arbitration.
    typedef struct packed {
        logic              vld;
        logic              found;
        logic [PRIO_W-1:0] best_p;
        logic [IRQ_W-1:0]  best_idx;
        logic [PRIO_W-1:0] run_p;
        logic              rd_pend;
        logic              rd_act;
        logic              rd_lvl;
    } tok_t;

    // State update broadcast to every cell at the end of a request.
    typedef struct packed {
        logic             en;
        logic             take;
        logic [IRQ_W-1:0] sel_line;
        logic             ret;
    } apply_t;

endpackage

// ----- hw/rtl/ipc_cell.sv -----
// One cell of the line chain: state of LANES lines plus one token stage.
// Depends on ipc_pkg.
module ipc_cell #(
    parameter int BASE       = 0,
    parameter int LINE_COUNT = ipc_pkg::LINE_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ipc_pkg::req_t   ctx,
    input  ipc_pkg::apply_t apl,
    input  ipc_pkg::tok_t   tok_i,
    output ipc_pkg::tok_t   tok_o
);
    import ipc_pkg::*;

    logic              pend_reg [LANES];
    logic              en_reg   [LANES];
    logic              act_reg  [LANES];
    logic              lvl_reg  [LANES];
    logic [PRIO_W-1:0] prio_reg [LANES];

    tok_t tok_reg;
    tok_t tok_next;

    always_comb
    begin
        logic masked;
        masked   = 1'b0;
        tok_next = tok_i;
        for (int k = 0; k < LANES; k++)
        begin
            if (BASE + k < LINE_COUNT)
            begin
                masked = ctx.primask || ctx.faultmask ||
                         (ctx.basepri != '0 && prio_reg[k] >= ctx.basepri);
                // Ascending order keeps the lowest line on a tie.
                if (pend_reg[k] && en_reg[k] && !masked &&
                    (!tok_next.found || prio_reg[k] < tok_next.best_p))
                begin
                    tok_next.found    = 1'b1;
                    tok_next.best_p   = prio_reg[k];
                    tok_next.best_idx = IRQ_W'(BASE + k);
                end
                if (ctx.run_exc == 8'(BASE + k + 16))
                begin
                    tok_next.run_p = prio_reg[k];
                end
                if (ctx.irq == IRQ_W'(BASE + k))
                begin
                    tok_next.rd_pend = pend_reg[k];
                    tok_next.rd_act  = act_reg[k];
                    tok_next.rd_lvl  = lvl_reg[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.vld <= 1'b0;
            for (int k = 0; k < LANES; k++)
            begin
                pend_reg[k] <= 1'b0;
                en_reg[k]   <= 1'b0;
                act_reg[k]  <= 1'b0;
                lvl_reg[k]  <= 1'b0;
                prio_reg[k] <= '0;
            end
        end
        else
        begin
            tok_reg <= tok_next;
            if (apl.en)
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    if (BASE + k < LINE_COUNT)
                    begin
                        if (ctx.irq == IRQ_W'(BASE + k))
                        begin
                            case (ctx.cmd)
                                CMD_SET_PEND: pend_reg[k] <= 1'b1;
                                CMD_CLR_PEND: pend_reg[k] <= 1'b0;
                                CMD_LVL_HIGH:
                                begin
                                    lvl_reg[k]  <= 1'b1;
                                    pend_reg[k] <= 1'b1;
                                end
                                CMD_LVL_LOW:  lvl_reg[k]  <= 1'b0;
                                CMD_WR_EN:    en_reg[k]   <= ctx.value[0];
                                CMD_WR_PRIO:  prio_reg[k] <= ctx.value;
                                default:      ;
                            endcase
                        end
                        if (apl.take && apl.sel_line == IRQ_W'(BASE + k))
                        begin
                            pend_reg[k] <= 1'b0;
                            act_reg[k]  <= 1'b1;
                        end
                        // Release the running line; re-pend while its level holds.
                        if (apl.ret && ctx.run_exc == 8'(BASE + k + 16))
                        begin
                            act_reg[k] <= 1'b0;
                            if (lvl_reg[k])
                            begin
                                pend_reg[k] <= 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    assign tok_o = tok_reg;

endmodule

// ----- hw/rtl/interrupt_priority_controller_top.sv -----
// Top level of the interrupt priority controller: sequencer, nesting depth,
// result register and the cell chain. Depends on ipc_pkg, ipc_cell and the defines header.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | ipc_pkg::req_t
//  rsp     | out       | rsp_valid / rsp_ready | ipc_pkg::rsp_t
//
// One request at a time; an arbitration token walks the chain one cell per cycle, and
// its value as it leaves the last cell forms the result.
// Reset clears every line's bits and priorities and the depth at once; no sweep.
// A waiting result holds the final update step until it is taken; a new request
// is accepted the cycle after the previous one has updated state.
`include "interrupt_priority_controller_top_defines.svh"

module interrupt_priority_controller_top #(
    parameter int LINE_COUNT = ipc_pkg::LINE_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ipc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ipc_pkg::rsp_t rsp
);
    import ipc_pkg::*;

    localparam int NCELL = (LINE_COUNT + LANES - 1) / LANES;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    state_t     state_reg;
    req_t       req_reg;
    tok_t       tok0_reg;
    tok_t       fin_reg;
    rsp_t       rsp_reg;
    logic       rsp_valid_reg;
    logic [7:0] depth_reg;

    tok_t   tok_w [NCELL+1];
    apply_t apl;

    logic       accept;
    logic       apply_fire;
    logic       line_ok;
    logic       word_ok;
    logic       ret_do;
    logic       take;
    logic       irq_is_sel;
    logic       irq_is_cur;
    logic [7:0] depth_next;
    rsp_t       rsp_next;
    tok_t       tok0_next;

    assign accept     = req_valid && req_ready;
    assign req_ready  = (state_reg == ST_IDLE);
    assign apply_fire = (state_reg == ST_APPLY) && (!rsp_valid_reg || rsp_ready);

    assign tok_w[0] = tok0_reg;

    for (genvar c = 0; c < NCELL; c++)
    begin : g_cell
        ipc_cell #(
            .BASE      (c * LANES),
            .LINE_COUNT(LINE_COUNT)
        ) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .ctx  (req_reg),
            .apl  (apl),
            .tok_i(tok_w[c]),
            .tok_o(tok_w[c+1])
        );
    end

    always_comb
    begin
        tok0_next          = '0;
        tok0_next.vld      = accept;
        tok0_next.run_p    = (req.run_exc == '0) ? THREAD_PRIO : '0;
    end

    always_comb
    begin
        line_ok = ({1'b0, req_reg.irq} < 9'(LINE_COUNT));
        word_ok = (req_reg.return_code == EXC_RET_HANDLER) ||
                  (req_reg.return_code == EXC_RET_THREAD_MSP) ||
                  (req_reg.return_code == EXC_RET_THREAD_PSP);
        ret_do  = (req_reg.cmd == CMD_RETURN) && word_ok;
        take    = (req_reg.cmd == CMD_TAKE) && fin_reg.found &&
                  (fin_reg.best_p < fin_reg.run_p);

        irq_is_sel = take && (fin_reg.best_idx == req_reg.irq);
        irq_is_cur = ret_do &&
                     ({1'b0, req_reg.run_exc} == ({1'b0, req_reg.irq} + 9'd16));

        depth_next = depth_reg;
        if (take && depth_reg != DEPTH_MAX)
        begin
            depth_next = depth_reg + 8'd1;
        end
        else if (ret_do && depth_reg != '0)
        begin
            depth_next = depth_reg - 8'd1;
        end

        rsp_next             = '0;
        rsp_next.sel_exc     = take ? (fin_reg.best_idx + EXC_LINE_BASE) : '0;
        rsp_next.taken       = take;
        rsp_next.return_ok   = ret_do;
        rsp_next.nest_depth  = depth_next;
        rsp_next.pending_bit = fin_reg.rd_pend;
        rsp_next.active_bit  = fin_reg.rd_act;
        case (req_reg.cmd)
            CMD_SET_PEND,
            CMD_LVL_HIGH:
            begin
                rsp_next.wake        = line_ok;
                rsp_next.pending_bit = line_ok;
            end
            CMD_CLR_PEND: rsp_next.pending_bit = 1'b0;
            CMD_TAKE:
            begin
                if (irq_is_sel)
                begin
                    rsp_next.pending_bit = 1'b0;
                    rsp_next.active_bit  = 1'b1;
                end
            end
            CMD_RETURN:
            begin
                if (irq_is_cur)
                begin
                    rsp_next.pending_bit = fin_reg.rd_pend | fin_reg.rd_lvl;
                    rsp_next.active_bit  = 1'b0;
                end
            end
            default: ;
        endcase

        apl          = '0;
        apl.en       = apply_fire;
        apl.take     = take;
        apl.sel_line = fin_reg.best_idx;
        apl.ret      = ret_do;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tok0_reg.vld  <= 1'b0;
            fin_reg.vld   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            depth_reg     <= '0;
        end
        else
        begin
            tok0_reg <= tok0_next;
            if (apply_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg   <= req;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // Catch the token as it leaves the last cell.
                    if (tok_w[NCELL].vld)
                    begin
                        fin_reg   <= tok_w[NCELL];
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    if (apply_fire)
                    begin
                        rsp_reg     <= rsp_next;
                        depth_reg   <= depth_next;
                        fin_reg.vld <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `IPC_ASSERT_NOW(a_taken_is_line, clk, rst_n, rsp_valid_reg && rsp_reg.taken, rsp_reg.sel_exc >= EXC_LINE_BASE, "taken result without a line exception number")
    `IPC_ASSERT_NOW(a_no_token_idle, clk, rst_n, state_reg == ST_IDLE, !tok_w[NCELL].vld, "arbitration token left the chain while idle")
    `IPC_ASSERT_NEXT(a_apply_shows, clk, rst_n, apply_fire, rsp_valid_reg, "state update without a result")
    `IPC_ASSERT_NEXT(a_depth_hold, clk, rst_n, !apply_fire, $stable(depth_reg), "nesting depth moved outside a state update")

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for interrupt_priority_controller_top: a queue-fed request driver with
// a line-state predictor, a response monitor, random idling and back-pressure.
// Depends on ipc_pkg and the controller RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ipc_pkg::*;

    localparam int LINES      = LINE_COUNT_DEF;
    localparam int CYCLE_MAX  = 1000000;
    localparam int TAIL_WAIT  = 30;
    localparam int PRINT_MAX  = 40;
    localparam int LONG_HOLD  = 300;
    localparam int HOLD_AT    = 900;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_ready;
    req_t  req       = '0;
    logic  rsp_valid;
    logic  rsp_ready = 1'b0;
    rsp_t  rsp;

    // Predictor copy of the per-line stores and the nesting depth
    bit [LINES-1:0] pend_vec;
    bit [LINES-1:0] en_vec;
    bit [LINES-1:0] act_vec;
    bit [LINES-1:0] lvl_vec;
    bit [7:0]       prio_tab [LINES];
    bit [7:0]       nest_cnt;

    req_t req_pending_q [$];
    rsp_t rsp_expected_q [$];

    int  err_cnt        = 0;
    int  cycle_cnt      = 0;
    int  rsp_seen       = 0;
    int  tx_gap         = 0;
    int  rx_stall       = 0;
    bit  long_hold_done = 1'b0;
    bit  idle_on        = 1'b1;

    interrupt_priority_controller_top #(
        .LINE_COUNT (LINES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit is_ret_word(input logic [31:0] w);
        return w == EXC_RET_HANDLER || w == EXC_RET_THREAD_MSP || w == EXC_RET_THREAD_PSP;
    endfunction

    // Apply one request to the predicted line state and return the response.
    function automatic rsp_t ctrl_step(input req_t r);
        rsp_t res;
        bit   in_range;
        bit   found;
        bit   masked;
        int   cur_line;
        int   sel_line;
        int   best;
        res      = '0;
        in_range = r.irq < LINES;
        cur_line = int'(r.run_exc) - 16;
        found    = 1'b0;
        sel_line = 0;
        case (r.cmd)
            CMD_SET_PEND:
                if (in_range)
                begin
                    pend_vec[r.irq] = 1'b1;
                    res.wake        = 1'b1;
                end
            CMD_CLR_PEND:
                if (in_range)
                    pend_vec[r.irq] = 1'b0;
            CMD_LVL_HIGH:
                if (in_range)
                begin
                    lvl_vec[r.irq]  = 1'b1;
                    pend_vec[r.irq] = 1'b1;
                    res.wake        = 1'b1;
                end
            CMD_LVL_LOW:
                if (in_range)
                    lvl_vec[r.irq] = 1'b0;
            CMD_TAKE:
            begin
                // system exceptions and out-of-range running lines block every take
                if (r.run_exc == 8'd0)
                    best = int'(THREAD_PRIO);
                else if (cur_line < 0 || cur_line >= LINES)
                    best = 0;
                else
                    best = int'(prio_tab[cur_line]);
                for (int i = 0; i < LINES; i++)
                begin
                    if (pend_vec[i] && en_vec[i])
                    begin
                        masked = r.primask || r.faultmask ||
                                 (r.basepri != 0 && prio_tab[i] >= r.basepri);
                        if (!masked && int'(prio_tab[i]) < best)
                        begin
                            best     = int'(prio_tab[i]);
                            found    = 1'b1;
                            sel_line = i;
                        end
                    end
                end
                if (found)
                begin
                    res.sel_exc        = 8'(sel_line) + EXC_LINE_BASE;
                    res.taken          = 1'b1;
                    pend_vec[sel_line] = 1'b0;
                    act_vec[sel_line]  = 1'b1;
                    if (nest_cnt != DEPTH_MAX)
                        nest_cnt++;
                end
            end
            CMD_RETURN:
                if (is_ret_word(r.return_code))
                begin
                    res.return_ok = 1'b1;
                    if (cur_line >= 0 && cur_line < LINES)
                    begin
                        act_vec[cur_line] = 1'b0;
                        if (lvl_vec[cur_line])
                            pend_vec[cur_line] = 1'b1;
                    end
                    if (nest_cnt != 8'd0)
                        nest_cnt--;
                end
            CMD_WR_EN:
                if (in_range)
                    en_vec[r.irq] = r.value[0];
            CMD_WR_PRIO:
                if (in_range)
                    prio_tab[r.irq] = r.value;
            default: ;
        endcase
        if (in_range)
        begin
            res.pending_bit = pend_vec[r.irq];
            res.active_bit  = act_vec[r.irq];
        end
        res.nest_depth = nest_cnt;
        return res;
    endfunction

    function automatic int pick_gap();
        int k;
        if (!idle_on)
            return 0;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        if (k < 90)
            return $urandom_range(1, 3);
        if (k < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic req_t mk_req(input cmd_t c, input logic [7:0] line,
                                    input logic [7:0] val, input logic [7:0] cur = 8'd0,
                                    input logic [31:0] rcode = EXC_RET_HANDLER);
        req_t r;
        r             = '0;
        r.cmd         = c;
        r.irq         = line;
        r.value       = val;
        r.run_exc     = cur;
        r.return_code = rcode;
        return r;
    endfunction

    function automatic req_t rand_req();
        req_t r;
        int   k;
        r = '0;
        k = $urandom_range(0, 99);
        if (k < 15)
            r.cmd = CMD_SET_PEND;
        else if (k < 20)
            r.cmd = CMD_CLR_PEND;
        else if (k < 28)
            r.cmd = CMD_LVL_HIGH;
        else if (k < 36)
            r.cmd = CMD_LVL_LOW;
        else if (k < 61)
            r.cmd = CMD_TAKE;
        else if (k < 76)
            r.cmd = CMD_RETURN;
        else if (k < 88)
            r.cmd = CMD_WR_EN;
        else
            r.cmd = CMD_WR_PRIO;
        if ($urandom_range(0, 9) == 0)
            r.irq = 8'($urandom_range(LINES, 255));
        else
            r.irq = 8'($urandom_range(0, LINES - 1));
        // small priorities make ties and basepri hits common
        if ($urandom_range(0, 3) == 0)
            r.value = 8'($urandom);
        else
            r.value = 8'($urandom_range(0, 15));
        if (r.cmd == CMD_WR_EN && $urandom_range(0, 4) != 0)
            r.value[0] = 1'b1;
        r.primask   = ($urandom_range(0, 9) == 0);
        r.faultmask = ($urandom_range(0, 9) == 0);
        r.basepri   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        k = $urandom_range(0, 9);
        if (k < 5)
            r.run_exc = 8'd0;
        else if (k < 8)
            r.run_exc = EXC_LINE_BASE + 8'($urandom_range(0, LINES - 1));
        else if (k < 9)
            r.run_exc = 8'($urandom_range(1, 15));
        else
            r.run_exc = 8'($urandom);
        k = $urandom_range(0, 9);
        if (k < 3)
            r.return_code = EXC_RET_HANDLER;
        else if (k < 5)
            r.return_code = EXC_RET_THREAD_MSP;
        else if (k < 8)
            r.return_code = EXC_RET_THREAD_PSP;
        else
            r.return_code = $urandom;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_cnt < PRINT_MAX)
            $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
        err_cnt++;
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t want;
        if (rsp_expected_q.size() == 0)
        begin
            report_mismatch("response with no request outstanding", got, 0);
            return;
        end
        want = rsp_expected_q.pop_front();
        if (got.sel_exc !== want.sel_exc)
            report_mismatch("sel_exc", got.sel_exc, want.sel_exc);
        if (got.taken !== want.taken)
            report_mismatch("taken", got.taken, want.taken);
        if (got.return_ok !== want.return_ok)
            report_mismatch("return_ok", got.return_ok, want.return_ok);
        if (got.wake !== want.wake)
            report_mismatch("wake", got.wake, want.wake);
        if (got.pending_bit !== want.pending_bit)
            report_mismatch("pending_bit", got.pending_bit, want.pending_bit);
        if (got.active_bit !== want.active_bit)
            report_mismatch("active_bit", got.active_bit, want.active_bit);
        if (got.nest_depth !== want.nest_depth)
            report_mismatch("nest_depth", got.nest_depth, want.nest_depth);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_pending_q.size() != 0 || req_valid || rsp_expected_q.size() != 0);
    endtask

    // Request driver: predict on acceptance, then offer the next queued request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            tx_gap    = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                rsp_expected_q.push_back(ctrl_step(req));
            if (!req_valid || req_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    req_valid <= 1'b0;
                end
                else if (req_pending_q.size() == 0)
                    req_valid <= 1'b0;
                else
                begin
                    req       <= req_pending_q.pop_front();
                    req_valid <= 1'b1;
                    tx_gap    = pick_gap();
                end
            end
        end
    end

    // Response monitor with random back-pressure and one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rx_stall  = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                check_result(rsp);
                rsp_seen++;
            end
            if (rsp_seen == HOLD_AT && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                rx_stall       = LONG_HOLD;
                rsp_ready     <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rx_stall  = pick_gap();
                rsp_ready <= (rx_stall == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_MAX)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        req_t r;

        // directed: extremes, masking, ties, returns and out-of-range lines
        req_pending_q.push_back(mk_req(CMD_WR_EN, 8'd0, 8'd1));
        req_pending_q.push_back(mk_req(CMD_WR_EN, 8'd63, 8'hFF));
        req_pending_q.push_back(mk_req(CMD_WR_EN, 8'd64, 8'd1));
        req_pending_q.push_back(mk_req(CMD_WR_PRIO, 8'd0, 8'h10));
        req_pending_q.push_back(mk_req(CMD_WR_PRIO, 8'd63, 8'h10));
        req_pending_q.push_back(mk_req(CMD_WR_PRIO, 8'd255, 8'h00));
        req_pending_q.push_back(mk_req(CMD_SET_PEND, 8'd0, 8'd0));
        req_pending_q.push_back(mk_req(CMD_SET_PEND, 8'd63, 8'd0));
        req_pending_q.push_back(mk_req(CMD_SET_PEND, 8'd255, 8'd0));
        r = mk_req(CMD_TAKE, 8'd0, 8'd0);
        r.primask = 1'b1;
        req_pending_q.push_back(r);
        r = mk_req(CMD_TAKE, 8'd0, 8'd0);
        r.faultmask = 1'b1;
        req_pending_q.push_back(r);
        r = mk_req(CMD_TAKE, 8'd0, 8'd0);
        r.basepri = 8'h10;
        req_pending_q.push_back(r);
        req_pending_q.push_back(mk_req(CMD_TAKE, 8'd0, 8'd0, 8'd5));
        req_pending_q.push_back(mk_req(CMD_TAKE, 8'd0, 8'd0, 8'd216));
        r = mk_req(CMD_TAKE, 8'd0, 8'd0);
        r.basepri = 8'h11;
        req_pending_q.push_back(r);
        req_pending_q.push_back(mk_req(CMD_TAKE, 8'd63, 8'd0, 8'd16));
        req_pending_q.push_back(mk_req(CMD_RETURN, 8'd0, 8'd0, 8'd16, 32'h0));
        req_pending_q.push_back(mk_req(CMD_LVL_HIGH, 8'd0, 8'd0));
        req_pending_q.push_back(mk_req(CMD_RETURN, 8'd0, 8'd0, 8'd16, EXC_RET_HANDLER));
        req_pending_q.push_back(mk_req(CMD_RETURN, 8'd0, 8'd0, 8'd16, EXC_RET_THREAD_MSP));
        req_pending_q.push_back(mk_req(CMD_LVL_LOW, 8'd0, 8'd0));
        req_pending_q.push_back(mk_req(CMD_CLR_PEND, 8'd0, 8'd0));
        req_pending_q.push_back(mk_req(CMD_TAKE, 8'd63, 8'd0));
        req_pending_q.push_back(mk_req(CMD_RETURN, 8'd63, 8'd0, 8'd79, EXC_RET_THREAD_PSP));
        req_pending_q.push_back(mk_req(CMD_RETURN, 8'd0, 8'd0, 8'd216, EXC_RET_HANDLER));
        req_pending_q.push_back(mk_req(CMD_WR_PRIO, 8'd0, 8'hFF));
        req_pending_q.push_back(mk_req(CMD_SET_PEND, 8'd0, 8'd0));
        req_pending_q.push_back(mk_req(CMD_TAKE, 8'd0, 8'd0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait_drained();

        // drive the nesting depth into saturation and back down past zero
        req_pending_q.push_back(mk_req(CMD_WR_PRIO, 8'd1, 8'd0));
        req_pending_q.push_back(mk_req(CMD_WR_EN, 8'd1, 8'd1));
        repeat (260)
        begin
            req_pending_q.push_back(mk_req(CMD_SET_PEND, 8'd1, 8'd0));
            req_pending_q.push_back(mk_req(CMD_TAKE, 8'd1, 8'd0));
        end
        repeat (261)
            req_pending_q.push_back(mk_req(CMD_RETURN, 8'd1, 8'd0, 8'd17, EXC_RET_HANDLER));
        wait_drained();

        // random phases; the third runs with no idling on either side
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_on = (ph != 2);
            repeat (260)
                req_pending_q.push_back(rand_req());
            wait_drained();
        end
        idle_on = 1'b1;

        repeat (TAIL_WAIT) @(posedge clk);
        if (rsp_expected_q.size() != 0)
            report_mismatch("responses still outstanding", rsp_expected_q.size(), 0);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
